/* rtl/gcd_pkg.sv */
// package for the great-circle distance pipeline: constants and the arctangent table
package gcd_pkg;

  localparam int unsigned AngleBits = 32;
  localparam int unsigned CordicStages = 30;
  localparam int unsigned SqrtSteps = 30;
  localparam int unsigned DistBits = 22;
  localparam int unsigned CordicW = 34;
  localparam int unsigned ZW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [CordicW-1:0] Q30One = 34'sh040000000;
  localparam logic [23:0] EarthRPiQ10 = 24'd11066658;

  // arctangent of 2^-i as a binary angle
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    begin
      case (idx)
        5'd0: r = 34'sh020000000;
        5'd1: r = 34'sh012E4051E;
        5'd2: r = 34'sh009FB385B;
        5'd3: r = 34'sh0051111D4;
        5'd4: r = 34'sh0028B0D43;
        5'd5: r = 34'sh00145D7E1;
        5'd6: r = 34'sh000A2F61E;
        5'd7: r = 34'sh000517C55;
        5'd8: r = 34'sh00028BE53;
        5'd9: r = 34'sh000145F2F;
        5'd10: r = 34'sh0000A2F98;
        5'd11: r = 34'sh0000517CC;
        5'd12: r = 34'sh000028BE6;
        5'd13: r = 34'sh0000145F3;
        5'd14: r = 34'sh00000A2FA;
        5'd15: r = 34'sh00000517D;
        5'd16: r = 34'sh0000028BE;
        5'd17: r = 34'sh00000145F;
        5'd18: r = 34'sh000000A30;
        5'd19: r = 34'sh000000518;
        5'd20: r = 34'sh00000028C;
        5'd21: r = 34'sh000000146;
        5'd22: r = 34'sh0000000A3;
        5'd23: r = 34'sh000000051;
        5'd24: r = 34'sh000000029;
        5'd25: r = 34'sh000000014;
        5'd26: r = 34'sh00000000A;
        5'd27: r = 34'sh000000005;
        5'd28: r = 34'sh000000003;
        5'd29: r = 34'sh000000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/gcd_cos.sv */
// pipelined cordic cosine of a binary angle, one stage per iteration
module gcd_cos (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [31:0]                           angle_i,
  output logic signed [gcd_pkg::CordicW-1:0]    cos_o
);
  localparam int unsigned N = gcd_pkg::CordicStages;
  localparam int unsigned W = gcd_pkg::CordicW;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic                neg_q [N+1];

  logic [31:0] r;
  logic        neg;

  // fold the angle into the right half plane
  always_comb begin
    neg = angle_i[31] ^ angle_i[30];
    r = neg ? (angle_i + 32'h8000_0000) : angle_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= gcd_pkg::CordicGain;
      y_q[0] <= '0;
      z_q[0] <= W'($signed(r));
      neg_q[0] <= neg;
    end
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - gcd_pkg::atan_tab(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + gcd_pkg::atan_tab(5'(i));
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  assign cos_o = neg_q[N] ? -x_q[N] : x_q[N];
endmodule

/* rtl/gcd_sqrt.sv */
// pipelined restoring square root of v << 30, one result bit per stage
module gcd_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] val_i,
  output logic [30:0] root_o
);
  localparam int unsigned N = gcd_pkg::SqrtSteps + 1;

  logic [61:0] rem_q  [N+1];
  logic [30:0] root_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, val_i, 30'd0};
      root_q[0] <= '0;
    end
  end

  // one bit per stage, most significant first
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int unsigned B = N - 1 - i;
    logic [63:0] trial;
    assign trial = ({33'd0, root_q[i]} << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({2'b00, rem_q[i]} >= trial) begin
          rem_q[i+1]  <= 62'({2'b00, rem_q[i]} - trial);
          root_q[i+1] <= root_q[i] | (31'd1 << B);
        end else begin
          rem_q[i+1]  <= rem_q[i];
          root_q[i+1] <= root_q[i];
        end
      end
    end
  end

  assign root_o = root_q[N];
endmodule

/* rtl/great_circle_distance.sv */
// top level: haversine great-circle distance pipeline
// Accepts one position pair per cycle while the pipeline is not stalled and
// returns the distance in nautical miles with 8 fraction bits. Each pair passes
// through 99 register stages: 31 cosine cordic stages, a product and haversine
// stage, a clamp stage, 32 square root stages, 31 vectoring cordic stages and
// three clamp and scaling stages. The whole pipeline advances when the output
// register is empty or being taken, so a stall on the master side holds every
// stage in place. No state is kept between pairs.
module great_circle_distance #(
  parameter int unsigned ANGLE_BITS = gcd_pkg::AngleBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lat_first[31:0], lon_first[63:32], lat_second[95:64], lon_second[127:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance_nm[21:0], zero fill [23:22]
  output logic [23:0]  m_axis_tdata
);
  localparam int unsigned W = gcd_pkg::CordicW;
  localparam int unsigned N = gcd_pkg::CordicStages;
  localparam int unsigned Lat = (N + 1) + 2 + (gcd_pkg::SqrtSteps + 2) + (N + 1) + 2;
  localparam logic [31:0] Mask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic en;
  logic [Lat-1:0] vld_q;
  logic out_vld_q;
  logic [21:0] out_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  logic [31:0] lat1, lon1, lat2, lon2;
  assign lat1 = s_axis_tdata[31:0] & Mask;
  assign lon1 = s_axis_tdata[63:32] & Mask;
  assign lat2 = s_axis_tdata[95:64] & Mask;
  assign lon2 = s_axis_tdata[127:96] & Mask;

  logic signed [W-1:0] c1, c2, cdl, cdn;
  gcd_cos u_cos_lat1 (.clk_i, .en_i(en), .angle_i(lat1), .cos_o(c1));
  gcd_cos u_cos_lat2 (.clk_i, .en_i(en), .angle_i(lat2), .cos_o(c2));
  gcd_cos u_cos_dlat (.clk_i, .en_i(en), .angle_i(lat2 - lat1), .cos_o(cdl));
  gcd_cos u_cos_dlon (.clk_i, .en_i(en), .angle_i(lon2 - lon1), .cos_o(cdn));

  // cos product and the two haversine terms
  logic signed [W-1:0] cc_q, hlat_q, hlon_q;
  logic signed [2*W-1:0] ccp;
  assign ccp = c1 * c2;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q   <= W'(ccp >>> 30);
      hlat_q <= (gcd_pkg::Q30One - cdl) >>> 1;
      hlon_q <= (gcd_pkg::Q30One - cdn) >>> 1;
    end
  end

  // weighted haversine term, clamped to [0, 1]
  logic signed [2*W-1:0] hp;
  logic signed [W:0] a_sum;
  logic [30:0] a_q, na_q;
  assign hp = cc_q * hlon_q;
  assign a_sum = (W+1)'(hlat_q) + (W+1)'(hp >>> 30);
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_sum < 0) begin
        a_q <= '0;
        na_q <= 31'h4000_0000;
      end else if (a_sum > (W+1)'(gcd_pkg::Q30One)) begin
        a_q <= 31'h4000_0000;
        na_q <= '0;
      end else begin
        a_q <= 31'(a_sum);
        na_q <= 31'(31'h4000_0000 - 31'(a_sum));
      end
    end
  end

  logic [30:0] sa, ca;
  gcd_sqrt u_sqrt_a  (.clk_i, .en_i(en), .val_i(a_q), .root_o(sa));
  gcd_sqrt u_sqrt_na (.clk_i, .en_i(en), .val_i(na_q), .root_o(ca));

  // vectoring cordic for the half central angle
  logic signed [W-1:0] vx_q [N+1];
  logic signed [W-1:0] vy_q [N+1];
  logic signed [W-1:0] vz_q [N+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q[0] <= W'(ca);
      vy_q[0] <= W'(sa);
      vz_q[0] <= '0;
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vy_q[i] > 0) begin
          vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] + gcd_pkg::atan_tab(5'(i));
        end else begin
          vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] - gcd_pkg::atan_tab(5'(i));
        end
      end
    end
  end

  // clamp angle, then scale to nautical miles
  logic [30:0] z_q;
  logic [54:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vz_q[N] < 0) z_q <= '0;
      else if (vz_q[N] > gcd_pkg::Q30One) z_q <= 31'h4000_0000;
      else z_q <= 31'(vz_q[N]);
      prod_q <= 55'(z_q) * 55'(gcd_pkg::EarthRPiQ10);
    end
  end

  logic [54:0] rnd;
  assign rnd = prod_q + 55'(64'h8000_0000);
  always_ff @(posedge clk_i) begin
    if (en) out_q <= rnd[53:32];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {2'b00, out_q};
endmodule

/* test/great_circle_distance_tb.sv */
// testbench for the great-circle distance pipeline: predictor, scoreboard, stimulus
module great_circle_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LatencyCycles = 120;
  localparam longint unsigned CycleLimit = 400000;
  localparam int unsigned RandomPairs = 1680;

  typedef struct packed {
    logic [31:0] lon_second;
    logic [31:0] lat_second;
    logic [31:0] lon_first;
    logic [31:0] lat_first;
  } pos_pair_t;

  // expected distances in arrival order, computed from each accepted pair
  class distance_board;
    logic [21:0] pending_q[$];
    int unsigned mismatches;

    function automatic longint asr(longint v, int unsigned s);
      return v >>> s;
    endfunction

    function automatic longint atan_step(int unsigned i);
      return longint'(gcd_pkg::atan_tab(5'(i)));
    endfunction

    function automatic logic [31:0] trim_angle(logic [31:0] raw);
      logic [31:0] keep;
      keep = ~((32'h1 << (32 - gcd_pkg::AngleBits)) - 32'h1);
      return raw & keep;
    endfunction

    // cosine of a binary angle in q30 by rotation cordic
    function automatic longint cosine_q30(logic [31:0] t);
      logic [31:0] r;
      bit neg;
      longint x, y, z, nx;
      r = t;
      neg = 0;
      x = longint'(gcd_pkg::CordicGain);
      y = 0;
      if (((t + 32'h40000000) & 32'h80000000) != 0) begin
        r = t + 32'h80000000;
        neg = 1;
      end
      z = longint'($signed(r));
      for (int unsigned i = 0; i < 30; i++) begin
        if (z >= 0) begin
          nx = x - asr(y, i);
          y = y + asr(x, i);
          z -= atan_step(i);
        end else begin
          nx = x + asr(y, i);
          y = y - asr(x, i);
          z += atan_step(i);
        end
        x = nx;
      end
      return neg ? -x : x;
    endfunction

    function automatic longint hav_q30(logic [31:0] t);
      return asr(64'sd1073741824 - cosine_q30(t), 1);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // half central angle by vectoring cordic, clamped to a quarter turn
    function automatic longint half_angle(longint y, longint x);
      longint z, nx;
      z = 0;
      for (int unsigned i = 0; i < 30; i++) begin
        if (y > 0) begin
          nx = x + asr(y, i);
          y = y - asr(x, i);
          z += atan_step(i);
        end else begin
          nx = x - asr(y, i);
          y = y + asr(x, i);
          z -= atan_step(i);
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > 64'sd1073741824) z = 64'sd1073741824;
      return z;
    endfunction

    function automatic logic [21:0] predict_distance(pos_pair_t p);
      logic [31:0] la1, lo1, la2, lo2;
      longint cc, a, z;
      longint unsigned sa, ca, d;
      la1 = trim_angle(p.lat_first);
      lo1 = trim_angle(p.lon_first);
      la2 = trim_angle(p.lat_second);
      lo2 = trim_angle(p.lon_second);
      cc = asr(cosine_q30(la1) * cosine_q30(la2), 30);
      a = hav_q30(la2 - la1) + asr(cc * hav_q30(lo2 - lo1), 30);
      if (a < 0) a = 0;
      if (a > 64'sd1073741824) a = 64'sd1073741824;
      sa = int_sqrt(longint'(unsigned'(a)) << 30);
      ca = int_sqrt((64'd1073741824 - a) << 30);
      z = half_angle(longint'(sa), longint'(ca));
      d = (z * 64'd11066658 + (64'd1 << 31)) >> 32;
      return d[21:0];
    endfunction

    function void note_request(pos_pair_t p);
      pending_q.push_back(predict_distance(p));
    endfunction

    function void check_distance(logic [23:0] data, output bit bad, output string msg);
      logic [21:0] want;
      bad = 0;
      if (pending_q.size() == 0) begin
        bad = 1;
        $sformat(msg, "unexpected distance %0d", data[21:0]);
        return;
      end
      want = pending_q.pop_front();
      if (data[21:0] !== want || data[23:22] !== 2'b00) begin
        bad = 1;
        $sformat(msg, "distance got %0d (fill %b) want %0d", data[21:0], data[23:22], want);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  distance_board board = new();
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;
  bit no_idle = 0;
  bit hold_sink = 0;

  great_circle_distance u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // note each accepted request and check each accepted distance
  always @(posedge clk_i) begin
    bit bad;
    string msg;
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_request(pos_pair_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_distance(m_axis_tdata, bad, msg);
      if (bad) report_mismatch(msg);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pair(pos_pair_t p);
    int unsigned n;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk_i);
    end
    s_axis_tdata <= p;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] any_lat();
    case ($urandom_range(0, 7))
      0: return 32'hC0000000;
      1: return 32'h40000000;
      2: return $urandom();
      default: return 32'(int'($urandom_range(0, 32'h80000000)) - 32'sh40000000);
    endcase
  endfunction

  function automatic pos_pair_t random_pair();
    pos_pair_t p;
    p.lat_first = any_lat();
    p.lon_first = $urandom();
    p.lat_second = any_lat();
    case ($urandom_range(0, 3))
      0: p.lon_second = p.lon_first + 32'h80000000 + $urandom_range(0, 255) - 128;
      1: p.lon_second = p.lon_first + $urandom_range(0, 1023);
      default: p.lon_second = $urandom();
    endcase
    if ($urandom_range(0, 9) == 0) p.lat_second = -p.lat_first;
    if ($urandom_range(0, 9) == 0) p.lat_second = p.lat_first;
    return p;
  endfunction

  // stimulus: directed corners, random pairs, hold-off, idle-free tail
  initial begin
    pos_pair_t p;
    logic [31:0] lat_pick[6] = '{32'hC0000000, 32'h40000000, 32'h0, 32'h80000000,
                                 32'h7FFFFFFF, 32'h00000001};
    int unsigned waited;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // identical points, poles, antipodes, lon wrap, out-of-range latitudes
    for (int i = 0; i < 6; i++) begin
      p = '{lon_second: 32'h80000000, lat_second: lat_pick[(i + 3) % 6],
            lon_first: 32'h7FFFFFFF, lat_first: lat_pick[i]};
      send_pair(p);
      p = '{lon_second: 32'h0, lat_second: lat_pick[i], lon_first: 32'h0,
            lat_first: lat_pick[i]};
      send_pair(p);
    end
    send_pair('{32'h80000000, 32'h0, 32'h0, 32'h0});
    send_pair('{32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h00000000});
    send_pair('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    send_pair('{32'h00000001, 32'h40000000, 32'hFFFFFFFF, 32'hC0000000});
    send_pair('{32'h40000000, 32'h20000000, 32'hC0000000, 32'hE0000000});
    for (int i = 0; i < RandomPairs; i++) begin
      if (i == 600) begin
        // long receiver hold-off while requests keep coming
        fork
          begin
            hold_sink = 1;
            for (waited = 0; waited < 400; waited++) @(posedge clk_i);
            hold_sink = 0;
          end
        join_none
      end
      if (i == RandomPairs - 200) no_idle = 1;
      send_pair(random_pair());
    end
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
    if (error_count == 0 && board.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
